/* hw/rtl/vpkf_pkg.sv */
// Shared constants, payload types and the letter weight table of the period key finder.
// No dependencies.
package vpkf_pkg;

    localparam int TEXT_DEPTH_DEF = 4096;
    localparam int MAX_PERIOD_DEF = 14;
    localparam int ALPHA          = 26;
    localparam logic [4:0] NO_KEY = 5'd26;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ANALYZE = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [3:0] key_length;
    } t_in;

    typedef struct packed {
        logic [3:0]  period;
        logic [3:0]  column;
        logic [4:0]  vigenere_key;
        logic [4:0]  var_beaufort_key;
        logic [4:0]  beaufort_key;
        logic [23:0] coincidence_sum;
        logic [23:0] pair_count;
        logic [12:0] column_letters;
        logic        last;
    } t_out;

    // ln(freq * 0.26) in signed Q3.8
    function automatic logic signed [11:0] log_weight(input logic [4:0] idx);
        logic signed [11:0] w;
        case (idx)
            5'd0:    w = 12'sd187;
            5'd1:    w = -12'sd268;
            5'd2:    w = -12'sd16;
            5'd3:    w = 12'sd56;
            5'd4:    w = 12'sd299;
            5'd5:    w = -12'sd166;
            5'd6:    w = -12'sd248;
            5'd7:    w = 12'sd40;
            5'd8:    w = 12'sd130;
            5'd9:    w = -12'sd1169;
            5'd10:   w = -12'sd567;
            5'd11:   w = -12'sd2;
            5'd12:   w = -12'sd92;
            5'd13:   w = 12'sd110;
            5'd14:   w = 12'sd152;
            5'd15:   w = -12'sd71;
            5'd16:   w = -12'sd991;
            5'd17:   w = 12'sd139;
            5'd18:   w = 12'sd211;
            5'd19:   w = 12'sd236;
            5'd20:   w = -12'sd98;
            5'd21:   w = -12'sd399;
            5'd22:   w = -12'sd183;
            5'd23:   w = -12'sd721;
            5'd24:   w = -12'sd159;
            5'd25:   w = -12'sd1065;
            default: w = 12'sd0;
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/vpkf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vpkf_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

/* hw/rtl/vigenere_period_key_finder.sv */
// Period key finder: letter store, per-column histogram walk and shift scoring.
// Depends on vpkf_pkg and vpkf_ram.
// Load and clear transfers are taken while idle; ready stays high, so they run back to back.
// Analyze of period p runs, per column: clear, walk of the column's letters, scoring on the
// shared multiplier (2 x 676 products, 26 coincidence terms, 1 pair term), drain and
// output, plus any result stall; ready is low for the whole analyze.
// Reset (i_rst_n low, synchronous) empties the store count and drops pending output.
module vigenere_period_key_finder
    import vpkf_pkg::*;
#(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int CBITS = $clog2(TEXT_DEPTH + 1);
    localparam int ABITS = $clog2(TEXT_DEPTH);
    localparam int OW    = (CBITS + 1 > 12) ? CBITS + 1 : 12;
    localparam int PW    = 2 * OW;
    localparam int AW    = PW + 5;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_SCORE = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // pass codes of the shared multiplier
    localparam logic [1:0] K_VIG  = 2'd0;
    localparam logic [1:0] K_BEAU = 2'd1;
    localparam logic [1:0] K_COIN = 2'd2;
    localparam logic [1:0] K_PAIR = 2'd3;

    localparam logic [4:0] LAST_IDX = 5'(ALPHA - 1);

    logic [2:0]         r_state;
    logic [CBITS-1:0]   r_count;
    logic [3:0]         r_period;
    logic [3:0]         r_col;
    logic [CBITS:0]     r_addr;
    logic               r_rd_v;
    logic [CBITS-1:0]   r_m;
    logic [CBITS-1:0]   r_hist [ALPHA];
    logic [1:0]         r_kind;
    logic [4:0]         r_s;
    logic [4:0]         r_j;

    logic signed [PW-1:0] r_prod;
    logic               r_pv;
    logic               r_plast;
    logic [1:0]         r_pkind;
    logic [4:0]         r_ps;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] r_best_a;
    logic signed [AW-1:0] r_best_b;
    logic [4:0]         r_key_a;
    logic [4:0]         r_key_b;
    logic [23:0]        r_coin;
    logic [23:0]        r_pairs;

    logic               r_out_valid;
    t_out               r_out;

    logic [4:0]         rd_data;
    logic               accept;
    logic               is_upper;
    logic               is_lower;
    logic [4:0]         letter;
    logic               do_write;
    logic               period_ok;
    logic               addr_live;
    logic [4:0]         hidx;
    logic [CBITS-1:0]   hsel;
    logic [5:0]         sum_a;
    logic [5:0]         sum_b;
    logic [4:0]         widx;
    logic signed [11:0] weight;
    logic signed [OW-1:0] op_x;
    logic signed [OW-1:0] op_y;
    logic signed [AW-1:0] acc_sum;
    logic [4:0]         vig_key;
    logic               out_free;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // fold A..Z and a..z to 0..25
    assign is_upper = (i_data.char_code >= 8'd65) && (i_data.char_code <= 8'd90);
    assign is_lower = (i_data.char_code >= 8'd97) && (i_data.char_code <= 8'd122);
    assign letter   = is_upper ? 5'(i_data.char_code - 8'd65) : 5'(i_data.char_code - 8'd97);
    assign do_write = accept && (i_data.mode == MODE_LOAD) && (is_upper || is_lower)
                      && (r_count < CBITS'(TEXT_DEPTH));

    assign period_ok = (i_data.key_length >= 4'd2)
                       && ({28'd0, i_data.key_length} <= 32'(MAX_PERIOD));

    // column walk visits col, col+p, col+2p, ... below the fill count
    assign addr_live = (r_addr < {1'b0, r_count});

    vpkf_ram #(
        .WIDTH (5),
        .DEPTH (TEXT_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_count[ABITS-1:0]),
        .i_wdata (letter),
        .i_re    ((r_state == S_WALK) && addr_live),
        .i_raddr (r_addr[ABITS-1:0]),
        .o_rdata (rd_data)
    );

    // one histogram read port: store data while walking, shift index j while scoring
    assign hidx = (r_state == S_WALK) ? rd_data : r_j;
    assign hsel = (hidx < 5'(ALPHA)) ? r_hist[hidx] : '0;

    // weight index: (j+s)%26 for the Vigenere family, (s-j+26)%26 for Beaufort
    assign sum_a  = {1'b0, r_j} + {1'b0, r_s};
    assign sum_b  = 6'd26 + {1'b0, r_s} - {1'b0, r_j};
    always_comb begin
        if (r_kind == K_BEAU) begin
            widx = (sum_b >= 6'd26) ? 5'(sum_b - 6'd26) : 5'(sum_b);
        end else begin
            widx = (sum_a >= 6'd26) ? 5'(sum_a - 6'd26) : 5'(sum_a);
        end
    end
    assign weight = log_weight(widx);

    // shared multiplier operands
    always_comb begin
        case (r_kind)
            K_VIG, K_BEAU: begin
                op_x = OW'({1'b0, hsel});
                op_y = OW'(weight);
            end
            K_COIN: begin
                op_x = OW'({1'b0, hsel});
                op_y = OW'({1'b0, hsel}) - OW'(1);
            end
            default: begin
                op_x = OW'({1'b0, r_m});
                op_y = OW'({1'b0, r_m}) - OW'(1);
            end
        endcase
    end

    assign acc_sum  = r_acc + AW'(r_prod);
    assign vig_key  = (r_key_a == NO_KEY || r_key_a == 5'd0) ? r_key_a : 5'd26 - r_key_a;
    assign out_free = !r_out_valid || i_ready;

    // histogram: clear per column, bump on each returning store read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            for (int k = 0; k < ALPHA; k++) begin
                r_hist[k] <= '0;
            end
        end else if (r_rd_v && (rd_data < 5'(ALPHA))) begin
            r_hist[rd_data] <= hsel + CBITS'(1);
        end
    end

    // product register and accumulate/compare stage
    always_ff @(posedge i_clk) begin
        r_prod  <= op_x * op_y;
        r_plast <= (r_kind == K_PAIR) || (r_j == LAST_IDX);
        r_pkind <= r_kind;
        r_ps    <= r_s;
        if (r_state == S_CLR) begin
            r_acc    <= '0;
            r_best_a <= '0;
            r_best_b <= '0;
            r_key_a  <= NO_KEY;
            r_key_b  <= NO_KEY;
        end else if (r_pv) begin
            if (r_plast) begin
                r_acc <= '0;
                case (r_pkind)
                    K_VIG: begin
                        if (acc_sum > r_best_a) begin
                            r_best_a <= acc_sum;
                            r_key_a  <= r_ps;
                        end
                    end
                    K_BEAU: begin
                        if (acc_sum > r_best_b) begin
                            r_best_b <= acc_sum;
                            r_key_b  <= r_ps;
                        end
                    end
                    K_COIN:  r_coin  <= acc_sum[23:0];
                    default: r_pairs <= acc_sum[23:0];
                endcase
            end else begin
                r_acc <= acc_sum;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out.period           <= r_period;
            r_out.column           <= r_col;
            r_out.vigenere_key     <= vig_key;
            r_out.var_beaufort_key <= r_key_a;
            r_out.beaufort_key     <= r_key_b;
            r_out.coincidence_sum  <= r_coin;
            r_out.pair_count       <= r_pairs;
            r_out.column_letters   <= 13'(r_m);
            r_out.last             <= (r_col + 4'd1 == r_period);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_v      <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_m         <= '0;
            r_kind      <= K_VIG;
            r_s         <= '0;
            r_j         <= '0;
        end else begin
            r_rd_v <= (r_state == S_WALK) && addr_live;
            r_pv   <= (r_state == S_SCORE);
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (do_write) begin
                        r_count <= r_count + CBITS'(1);
                    end
                    if (accept && (i_data.mode == MODE_CLEAR)) begin
                        r_count <= '0;
                    end
                    if (accept && (i_data.mode == MODE_ANALYZE) && period_ok) begin
                        r_period <= i_data.key_length;
                        r_col    <= '0;
                        r_state  <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_addr  <= (CBITS + 1)'(r_col);
                    r_m     <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (addr_live) begin
                        r_addr <= r_addr + (CBITS + 1)'(r_period);
                    end
                    if (r_rd_v) begin
                        r_m <= r_m + CBITS'(1);
                    end
                    if (!addr_live && !r_rd_v) begin
                        r_kind  <= K_VIG;
                        r_s     <= '0;
                        r_j     <= '0;
                        r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    case (r_kind)
                        K_VIG, K_BEAU: begin
                            if (r_j == LAST_IDX) begin
                                r_j <= '0;
                                if (r_s == LAST_IDX) begin
                                    r_s    <= '0;
                                    r_kind <= r_kind + 2'd1;
                                end else begin
                                    r_s <= r_s + 5'd1;
                                end
                            end else begin
                                r_j <= r_j + 5'd1;
                            end
                        end
                        K_COIN: begin
                            if (r_j == LAST_IDX) begin
                                r_j    <= '0;
                                r_kind <= K_PAIR;
                            end else begin
                                r_j <= r_j + 5'd1;
                            end
                        end
                        default: begin
                            r_state <= S_DRAIN;
                        end
                    endcase
                end
                S_DRAIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_col + 4'd1 == r_period) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= r_col + 4'd1;
                            r_state <= S_CLR;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* hw/rtl/vpkf_checker.sv */
// Port-level checks on the result channel of the period key finder, bound to the top level.
// Depends on vpkf_pkg.
module vpkf_port_checks
    import vpkf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.column < i_out_data.period)
        else $error("column beyond period");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.last |-> i_out_data.column + 4'd1 == i_out_data.period)
        else $error("last flag on wrong column");

    a_nokey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.vigenere_key == NO_KEY
        |-> i_out_data.var_beaufort_key == NO_KEY)
        else $error("Vigenere and variant keys disagree on none");

endmodule

bind vigenere_period_key_finder vpkf_port_checks u_vpkf_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);
